// ----- design/kmer_count_two_level_search_assert.svh -----
// Assertion macros shared by the k-mer index search block.
`ifndef KMER_COUNT_TWO_LEVEL_SEARCH_ASSERT_SVH
`define KMER_COUNT_TWO_LEVEL_SEARCH_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KCTS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define KCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/kcts_pkg.sv -----
// Shared types and constants of the k-mer index search block.
`timescale 1ns / 1ps

package kcts_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_PREFIX = 2'd0,
      OP_WRITE_SUFFIX = 2'd1,
      OP_QUERY        = 2'd2
   } op_type;

   localparam logic [1:0] CSR_PREFIX_BASES   = 2'd0;
   localparam logic [1:0] CSR_SUFFIX_BASES   = 2'd1;
   localparam logic [1:0] CSR_PREFIX_ENTRIES = 2'd2;
   localparam logic [1:0] CSR_SUFFIX_ENTRIES = 2'd3;

   localparam int OP_W       = 2;
   localparam int INDEX_W    = 16;
   localparam int KEY_W      = 64;
   localparam int VALUE_W    = 32;
   localparam int BASES_W    = 5;
   localparam int PENTRIES_W = 13;
   localparam int SENTRIES_W = 17;
   localparam int CSR_DATA_W = 17;

   localparam int PFX_KEY_W = 32;
   localparam int FIRST_W   = 16;
   localparam int SFX_KEY_W = 62;
   localparam int COUNT_W   = 32;

   localparam logic [BASES_W-1:0] PREFIX_BASES_MAX   = 5'd16;
   localparam logic [BASES_W-1:0] PREFIX_BASES_RESET = 5'd8;
   localparam logic [BASES_W-1:0] SUFFIX_BASES_RESET = 5'd23;

endpackage

// ----- design/kcts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kcts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/kmer_count_two_level_search.sv -----
// Top level of the two-level k-mer index search block.
`timescale 1ns / 1ps
//
// Input channel req_*: operation 0 writes a prefix entry (key, first suffix index),
// operation 1 writes a suffix entry (key, count), operation 2 looks up a k-mer,
// operation 3 is dropped. Writes take effect at the transfer and give no result.
// A query gives one result on rsp_* (found, kmer_count; count 0 when absent).
// Configuration port csr_* is always ready; write it only while the block is idle.
// A query binary-searches the prefix table and then that prefix's suffix range with
// one shared midpoint/compare unit; each probe is a RAM read (ST_PROBE) plus a compare
// (ST_CHECK). req_stall is high from the query transfer until its result is loaded
// into the output register; writes are taken back to back while no query is in
// progress.
// A result waiting on rsp_stall is held in the output register; writes and the next
// query are still taken, and that query parks its result until the register frees.
// Reset (synchronous) clears the sequencer, the output valid and the configuration
// registers to their defaults; table contents are undefined until written.
//

`include "kmer_count_two_level_search_assert.svh"

module kmer_count_two_level_search #(
   parameter int PREFIX_DEPTH = 4096,
   parameter int SUFFIX_DEPTH = 65536,
   parameter int MAX_BASES    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kcts_pkg::OP_W-1:0]           req_operation,
   input  logic [kcts_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [kcts_pkg::KEY_W-1:0]          req_key_bits,
   input  logic [kcts_pkg::VALUE_W-1:0]        req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [kcts_pkg::COUNT_W-1:0]        rsp_kmer_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [kcts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PAW = $clog2(PREFIX_DEPTH);
   localparam int SAW = $clog2(SUFFIX_DEPTH);
   localparam int IW  = (PAW > SAW) ? PAW : SAW;
   localparam int PCW = $clog2(PREFIX_DEPTH + 1);
   localparam int SCW = $clog2(SUFFIX_DEPTH + 1);
   localparam int PW  = kcts_pkg::PFX_KEY_W + kcts_pkg::FIRST_W;
   localparam int SW  = kcts_pkg::SFX_KEY_W + kcts_pkg::COUNT_W;
   localparam logic [kcts_pkg::KEY_W-1:0] KEY_MASK = (2 * MAX_BASES >= kcts_pkg::KEY_W) ?
      {kcts_pkg::KEY_W{1'b1}} : ((64'd1 << (2 * MAX_BASES)) - 64'd1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PROBE,
      ST_CHECK,
      ST_NEXT,
      ST_RESP
   } state_type;

   // Configuration registers
   logic [kcts_pkg::BASES_W-1:0]    prefix_bases_ff, prefix_bases_in;
   logic [kcts_pkg::BASES_W-1:0]    suffix_bases_ff, suffix_bases_in;
   logic [kcts_pkg::PENTRIES_W-1:0] prefix_entries_ff, prefix_entries_in;
   logic [kcts_pkg::SENTRIES_W-1:0] suffix_entries_ff, suffix_entries_in;

   // Sequencer and search registers
   state_type                       state_ff, state_in;
   logic [kcts_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [kcts_pkg::PFX_KEY_W-1:0]  pfx_ff, pfx_in;
   logic [kcts_pkg::SFX_KEY_W-1:0]  sfx_ff, sfx_in;
   logic [PCW-1:0]                  np_ff, np_in;
   logic [SCW-1:0]                  ns_ff, ns_in;
   logic [IW-1:0]                   lo_ff, lo_in;
   logic [IW-1:0]                   hi_ff, hi_in;
   logic [IW-1:0]                   mid_ff, mid_in;
   logic                            last_probe_ff, last_probe_in;
   logic                            sfx_phase_ff, sfx_phase_in;
   logic [kcts_pkg::FIRST_W-1:0]    start_ff, start_in;
   logic                            res_found_ff, res_found_in;
   logic [kcts_pkg::COUNT_W-1:0]    res_count_ff, res_count_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [kcts_pkg::COUNT_W-1:0]    rsp_kmer_count_ff, rsp_kmer_count_in;

   // Datapath
   logic                            req_accept;
   logic                            pfx_we, sfx_we;
   logic [31:0]                     idx_ext;
   logic [PW-1:0]                   pfx_rd;
   logic [SW-1:0]                   sfx_rd;
   logic [PAW-1:0]                  pfx_raddr;
   logic [SAW-1:0]                  sfx_raddr;
   logic [IW-1:0]                   probe_idx;
   logic [IW-1:0]                   mid_calc;
   logic [IW-1:0]                   lo_next;
   logic [IW:0]                     mid_sum;
   logic [kcts_pkg::BASES_W-1:0]    pb_sat;
   logic [5:0]                      pb2, sb2;
   logic [kcts_pkg::KEY_W-1:0]      key_m, key_shr, sfx_mask;
   logic [kcts_pkg::PFX_KEY_W-1:0]  pfx_mask;
   logic [PCW-1:0]                  np_sat;
   logic [SCW-1:0]                  ns_sat;
   logic [kcts_pkg::SFX_KEY_W-1:0]  cmp_key, cmp_data;
   logic                            cmp_less, cmp_eq;
   logic [kcts_pkg::PFX_KEY_W-1:0]  rd_pfx_key;
   logic [kcts_pkg::FIRST_W-1:0]    rd_first;
   logic [kcts_pkg::SFX_KEY_W-1:0]  rd_sfx_key;
   logic [kcts_pkg::COUNT_W-1:0]    rd_count;
   logic [31:0]                     start32, end32, ns32, first32;
   logic                            out_free;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign idx_ext    = 32'(req_entry_index);

   assign pfx_we = req_accept &&
                   (req_operation == kcts_pkg::OP_WRITE_PREFIX) &&
                   (idx_ext < 32'(PREFIX_DEPTH));
   assign sfx_we = req_accept &&
                   (req_operation == kcts_pkg::OP_WRITE_SUFFIX) &&
                   (idx_ext < 32'(SUFFIX_DEPTH));

   // Shared search unit: upper midpoint and one compare
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff} + {{IW{1'b0}}, 1'b1};
   assign mid_calc  = mid_sum[IW:1];
   assign probe_idx = (lo_ff < hi_ff) ? mid_calc : lo_ff;
   assign lo_next   = lo_ff + {{(IW-1){1'b0}}, 1'b1};
   assign pfx_raddr = (state_ff == ST_CHECK) ? PAW'(lo_next) : PAW'(probe_idx);
   assign sfx_raddr = SAW'(probe_idx);

   assign rd_pfx_key = pfx_rd[PW-1:kcts_pkg::FIRST_W];
   assign rd_first   = pfx_rd[kcts_pkg::FIRST_W-1:0];
   assign rd_sfx_key = sfx_rd[SW-1:kcts_pkg::COUNT_W];
   assign rd_count   = sfx_rd[kcts_pkg::COUNT_W-1:0];

   assign cmp_key  = sfx_phase_ff ? sfx_ff : kcts_pkg::SFX_KEY_W'(pfx_ff);
   assign cmp_data = sfx_phase_ff ? rd_sfx_key : kcts_pkg::SFX_KEY_W'(rd_pfx_key);
   assign cmp_less = (cmp_key < cmp_data);
   assign cmp_eq   = (cmp_key == cmp_data);

   // Split the k-mer into prefix and suffix
   assign pb_sat   = (prefix_bases_ff > kcts_pkg::PREFIX_BASES_MAX) ?
                     kcts_pkg::PREFIX_BASES_MAX : prefix_bases_ff;
   assign pb2      = {pb_sat, 1'b0};
   assign sb2      = {suffix_bases_ff, 1'b0};
   assign key_m    = key_ff & KEY_MASK;
   assign key_shr  = key_m >> sb2;
   assign sfx_mask = ~({kcts_pkg::KEY_W{1'b1}} << sb2);
   assign pfx_mask = ~({kcts_pkg::PFX_KEY_W{1'b1}} << pb2);

   assign np_sat = (32'(prefix_entries_ff) > 32'(PREFIX_DEPTH)) ?
                   PCW'(PREFIX_DEPTH) : PCW'(prefix_entries_ff);
   assign ns_sat = (32'(suffix_entries_ff) > 32'(SUFFIX_DEPTH)) ?
                   SCW'(SUFFIX_DEPTH) : SCW'(suffix_entries_ff);

   assign start32 = 32'(start_ff);
   assign ns32    = 32'(ns_ff);
   assign first32 = 32'(rd_first);
   assign end32   = 32'(rd_first) - 32'd1;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   kcts_ram #(
      .WIDTH (PW),
      .DEPTH (PREFIX_DEPTH)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (pfx_we),
      .wr_addr (PAW'(idx_ext)),
      .wr_data ({req_key_bits[kcts_pkg::PFX_KEY_W-1:0],
                 req_entry_value[kcts_pkg::FIRST_W-1:0]}),
      .rd_addr (pfx_raddr),
      .rd_data (pfx_rd)
   );

   kcts_ram #(
      .WIDTH (SW),
      .DEPTH (SUFFIX_DEPTH)
   ) u_suffix_ram (
      .clock   (clock),
      .wr_en   (sfx_we),
      .wr_addr (SAW'(idx_ext)),
      .wr_data ({req_key_bits[kcts_pkg::SFX_KEY_W-1:0], req_entry_value}),
      .rd_addr (sfx_raddr),
      .rd_data (sfx_rd)
   );

   always_comb begin
      prefix_bases_in   = prefix_bases_ff;
      suffix_bases_in   = suffix_bases_ff;
      prefix_entries_in = prefix_entries_ff;
      suffix_entries_in = suffix_entries_ff;
      state_in          = state_ff;
      key_in            = key_ff;
      pfx_in            = pfx_ff;
      sfx_in            = sfx_ff;
      np_in             = np_ff;
      ns_in             = ns_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      mid_in            = mid_ff;
      last_probe_in     = last_probe_ff;
      sfx_phase_in      = sfx_phase_ff;
      start_in          = start_ff;
      res_found_in      = res_found_ff;
      res_count_in      = res_count_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_found_in      = rsp_found_ff;
      rsp_kmer_count_in = rsp_kmer_count_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            kcts_pkg::CSR_PREFIX_BASES:   prefix_bases_in = csr_wdata[kcts_pkg::BASES_W-1:0];
            kcts_pkg::CSR_SUFFIX_BASES:   suffix_bases_in = csr_wdata[kcts_pkg::BASES_W-1:0];
            kcts_pkg::CSR_PREFIX_ENTRIES: begin
               prefix_entries_in = csr_wdata[kcts_pkg::PENTRIES_W-1:0];
            end
            kcts_pkg::CSR_SUFFIX_ENTRIES: begin
               suffix_entries_in = csr_wdata[kcts_pkg::SENTRIES_W-1:0];
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_operation == kcts_pkg::OP_QUERY)) begin
               key_in   = req_key_bits;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            pfx_in       = key_shr[kcts_pkg::PFX_KEY_W-1:0] & pfx_mask;
            sfx_in       = key_m[kcts_pkg::SFX_KEY_W-1:0] & sfx_mask[kcts_pkg::SFX_KEY_W-1:0];
            np_in        = np_sat;
            ns_in        = ns_sat;
            lo_in        = '0;
            hi_in        = IW'(np_sat - PCW'(1));
            sfx_phase_in = 1'b0;
            if ((np_sat == '0) || (ns_sat == '0)) begin
               res_found_in = 1'b0;
               res_count_in = '0;
               state_in     = ST_RESP;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // RAM read is issued at probe_idx this cycle
            mid_in        = probe_idx;
            last_probe_in = !(lo_ff < hi_ff);
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (!last_probe_ff) begin
               if (cmp_less) begin
                  hi_in = mid_ff - {{(IW-1){1'b0}}, 1'b1};
               end else begin
                  lo_in = mid_ff;
               end
               state_in = ST_PROBE;
            end else if (sfx_phase_ff) begin
               res_found_in = cmp_eq;
               res_count_in = cmp_eq ? rd_count : '0;
               state_in     = ST_RESP;
            end else if (!cmp_eq) begin
               res_found_in = 1'b0;
               res_count_in = '0;
               state_in     = ST_RESP;
            end else if (32'(lo_ff) == (32'(np_ff) - 32'd1)) begin
               // Final prefix: range runs to the last suffix in use
               if (first32 >= ns32) begin
                  res_found_in = 1'b0;
                  res_count_in = '0;
                  state_in     = ST_RESP;
               end else begin
                  lo_in        = IW'(first32);
                  hi_in        = IW'(ns32 - 32'd1);
                  sfx_phase_in = 1'b1;
                  state_in     = ST_PROBE;
               end
            end else begin
               // Fetch the next prefix entry to bound the range
               start_in = rd_first;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if ((rd_first == '0) || (start32 >= ns32) || (end32 < start32)) begin
               res_found_in = 1'b0;
               res_count_in = '0;
               state_in     = ST_RESP;
            end else begin
               lo_in        = IW'(start32);
               hi_in        = (end32 >= ns32) ? IW'(ns32 - 32'd1) : IW'(end32);
               sfx_phase_in = 1'b1;
               state_in     = ST_PROBE;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_found_in      = res_found_ff;
               rsp_kmer_count_in = res_count_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         prefix_bases_ff   <= kcts_pkg::PREFIX_BASES_RESET;
         suffix_bases_ff   <= kcts_pkg::SUFFIX_BASES_RESET;
         prefix_entries_ff <= kcts_pkg::PENTRIES_W'(1);
         suffix_entries_ff <= kcts_pkg::SENTRIES_W'(1);
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         prefix_bases_ff   <= prefix_bases_in;
         suffix_bases_ff   <= suffix_bases_in;
         prefix_entries_ff <= prefix_entries_in;
         suffix_entries_ff <= suffix_entries_in;
      end
      key_ff            <= key_in;
      pfx_ff            <= pfx_in;
      sfx_ff            <= sfx_in;
      np_ff             <= np_in;
      ns_ff             <= ns_in;
      lo_ff             <= lo_in;
      hi_ff             <= hi_in;
      mid_ff            <= mid_in;
      last_probe_ff     <= last_probe_in;
      sfx_phase_ff      <= sfx_phase_in;
      start_ff          <= start_in;
      res_found_ff      <= res_found_in;
      res_count_ff      <= res_count_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_kmer_count_ff <= rsp_kmer_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_kmer_count = rsp_kmer_count_ff;

   `KCTS_ASSERT_SAME(a_probe_bounds, state_ff == ST_PROBE, lo_ff <= hi_ff,
      "search bounds crossed at probe")
   `KCTS_ASSERT_SAME(a_miss_zero, rsp_valid_ff && !rsp_found_ff, rsp_kmer_count_ff == '0,
      "miss reported with nonzero count")
   `KCTS_ASSERT_NEXT(a_query_starts, req_accept && (req_operation == kcts_pkg::OP_QUERY),
      state_ff == ST_SETUP, "query transfer did not start a search")
   `KCTS_ASSERT_SAME(a_rsp_from_resp, $rose(rsp_valid_ff), $past(state_ff) == ST_RESP,
      "result raised outside the response step")

endmodule
